[rtl/tsp_pkg.sv]
package tsp_pkg;
   localparam int MaxCitiesDefault = 16;
   localparam int CostBitsDefault = 16;
   localparam int CITY_W = 4;
   localparam int CNT_W = 5;
   localparam int TOUR_W = 20;
   localparam int SUM_W = 21;
   localparam int EDGE_W = 16;
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_START = 1'b1;

   typedef struct packed {
      logic              action;
      logic [CITY_W-1:0] from_city;
      logic [CITY_W-1:0] to_city;
      logic [EDGE_W-1:0] edge_cost;
   } req_word_type;

   typedef struct packed {
      logic [CITY_W-1:0] position;
      logic [CITY_W-1:0] city;
      logic [TOUR_W-1:0] tour_cost;
      logic              found;
      logic              last;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic init;      // clear search state, depth 1
      logic step;      // perform one search step (read data valid)
      logic emit_init; // clear emit index
      logic emit_next; // advance emit index
   } tsp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic done;      // search finished
      logic have_tour;
      logic emit_last;
   } tsp_sts_type;
endpackage

[rtl/tsp_datapath.sv]
module tsp_datapath
   import tsp_pkg::*;
#(
   parameter int MAX_CITIES = MaxCitiesDefault,
   parameter int COST_BITS = CostBitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_en,
   input  req_word_type      req_word,
   input  logic [CNT_W-1:0]  n_cities,
   input  tsp_cmd_type       cmd,
   output tsp_sts_type       sts,
   output rsp_word_type      emit_word
);
   localparam int DW = $clog2(MAX_CITIES);
   localparam int AW = 2 * DW;

   logic [COST_BITS-1:0] mem [0:MAX_CITIES*MAX_CITIES-1];
   logic [COST_BITS-1:0] rd_data_ff;

   logic [CITY_W-1:0] path_ff [0:MAX_CITIES-1];
   logic [CITY_W-1:0] best_ff [0:MAX_CITIES-1];
   logic [CNT_W-1:0]  cand_ff [0:MAX_CITIES-1];
   logic [SUM_W-1:0]  pcost_ff [0:MAX_CITIES-1];
   logic [MAX_CITIES-1:0] vis_ff;
   logic [SUM_W-1:0]  best_cost_ff;
   logic              have_ff;
   logic [DW:0]       d_ff;
   logic              done_ff;
   // phase 0: edge to c, phase 1: return edge c->0
   logic              ret_ff;
   logic [CITY_W-1:0] emit_ff;

   logic [DW-1:0] d_i, dm1_i;
   logic [CNT_W-1:0] c;
   logic [CITY_W-1:0] prev_city;
   logic [AW-1:0] rd_addr;
   logic [SUM_W-1:0] sum;

   assign d_i = d_ff[DW-1:0];
   assign dm1_i = DW'(d_ff - 1'b1);
   assign c = cand_ff[d_i];
   assign prev_city = path_ff[dm1_i];
   assign sum = ret_ff ? pcost_ff[d_i] + SUM_W'(rd_data_ff)
                       : pcost_ff[dm1_i] + SUM_W'(rd_data_ff);

   // cost memory: load port and one registered read
   always_comb begin
      if (ret_ff) rd_addr = {path_ff[d_i][DW-1:0], DW'(0)};
      else rd_addr = {prev_city[DW-1:0], c[DW-1:0]};
   end
   always_ff @(posedge clock) begin
      if (load_en && 32'(req_word.from_city) < MAX_CITIES &&
          32'(req_word.to_city) < MAX_CITIES)
         mem[{req_word.from_city[DW-1:0], req_word.to_city[DW-1:0]}] <=
            COST_BITS'(req_word.edge_cost);
      rd_data_ff <= mem[rd_addr];
   end

   // search step: unvisited candidate needs an address phase, then a decide phase;
   // visited candidate or pop is done in the address phase alone
   logic phase_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff <= '0; done_ff <= 1'b1; have_ff <= 1'b0; vis_ff <= MAX_CITIES'(1);
         ret_ff <= 1'b0; phase_ff <= 1'b0; best_cost_ff <= '0;
         for (int i = 0; i < MAX_CITIES; i++) begin
            path_ff[i] <= '0; best_ff[i] <= '0; cand_ff[i] <= '0; pcost_ff[i] <= '0;
         end
      end else if (cmd.init) begin
         for (int i = 0; i < MAX_CITIES; i++) begin
            path_ff[i] <= '0; best_ff[i] <= '0; pcost_ff[i] <= '0;
            cand_ff[i] <= (i == 1) ? CNT_W'(1) : '0;
         end
         vis_ff <= MAX_CITIES'(1);
         d_ff <= (DW+1)'(1);
         have_ff <= 1'b0; best_cost_ff <= '0;
         done_ff <= (n_cities < CNT_W'(2));
         ret_ff <= 1'b0; phase_ff <= 1'b0;
      end else if (cmd.step && !done_ff) begin
         if (!phase_ff) begin
            // address cycle; pop immediately when candidates run out
            if (!ret_ff && c >= n_cities) begin
               if (d_ff == (DW+1)'(1)) done_ff <= 1'b1;
               else vis_ff[path_ff[DW'(d_ff - 2'd1) ]] <= 1'b0;
               d_ff <= d_ff - 1'b1;
            end else if (!ret_ff && vis_ff[c[DW-1:0]]) begin
               cand_ff[d_i] <= c + 1'b1;
            end else begin
               phase_ff <= 1'b1;
            end
         end else begin
            phase_ff <= 1'b0;
            if (ret_ff) begin
               ret_ff <= 1'b0;
               if (rd_data_ff != '0 && (!have_ff || sum < best_cost_ff)) begin
                  for (int i = 0; i < MAX_CITIES; i++) best_ff[i] <= path_ff[i];
                  best_cost_ff <= sum; have_ff <= 1'b1;
               end
            end else begin
               cand_ff[d_i] <= c + 1'b1;
               if (rd_data_ff != '0) begin
                  path_ff[d_i] <= c[CITY_W-1:0];
                  pcost_ff[d_i] <= sum;
                  if (CNT_W'(d_ff) + 1'b1 < n_cities) begin
                     vis_ff[c[DW-1:0]] <= 1'b1;
                     d_ff <= d_ff + 1'b1;
                     cand_ff[DW'(d_ff + 1'b1)] <= CNT_W'(1);
                  end else begin
                     ret_ff <= 1'b1;
                  end
               end
            end
         end
      end
   end

   // result index
   always_ff @(posedge clock) begin
      if (reset || cmd.emit_init) emit_ff <= '0;
      else if (cmd.emit_next) emit_ff <= emit_ff + 1'b1;
   end

   assign sts.done = done_ff;
   assign sts.have_tour = have_ff;
   assign sts.emit_last = (CNT_W'(emit_ff) + 1'b1 == n_cities);

   always_comb begin
      emit_word.position = have_ff ? emit_ff : '0;
      emit_word.city = have_ff ? best_ff[emit_ff[DW-1:0]] : '0;
      emit_word.tour_cost = have_ff ? best_cost_ff[TOUR_W-1:0] : '0;
      emit_word.found = have_ff;
      emit_word.last = have_ff ? sts.emit_last : 1'b1;
   end
endmodule

[rtl/tsp_control.sv]
module tsp_control
   import tsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  tsp_sts_type sts,
   output tsp_cmd_type cmd,
   output logic        busy,
   output logic        emit
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      emit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               cmd.init = 1'b1; state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (sts.done) begin
               cmd.emit_init = 1'b1; state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            emit = 1'b1;
            cmd.emit_next = 1'b1;
            if (!sts.have_tour || sts.emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);
endmodule

[rtl/tsp_exhaustive_tour_search.sv]
// Exhaustive tour search. A load word (action 0) writes one cost entry; busy stays low,
// so loads can follow back to back. A start word raises busy from the next cycle. The
// search reads the memory and then decides for each unvisited candidate, skips each
// already visited candidate and pops each exhausted depth in the read step alone, reads
// and then decides the return edge of each complete path, and finally sees the end. It
// then emits the best tour one city a cycle on rsp_valid (or one not-found word) and
// drops busy after the last word. The receiver cannot stall: results come one per cycle.
// Write csr_wr_data only while busy is low.
module tsp_exhaustive_tour_search
   import tsp_pkg::*;
#(
   parameter int MAX_CITIES = MaxCitiesDefault,
   parameter int COST_BITS = CostBitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_word_type      req_word,
   output logic              rsp_valid,
   output rsp_word_type      rsp_word,
   input  logic              csr_wr_en,
   input  logic [CNT_W-1:0]  csr_wr_data
);
   logic [CNT_W-1:0] count_ff, n_sat;
   tsp_cmd_type cmd;
   tsp_sts_type sts;
   logic accept, emit;
   rsp_word_type emit_word;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) count_ff <= CNT_W'(16);
      else if (csr_wr_en) count_ff <= csr_wr_data;
   end
   assign n_sat = (32'(count_ff) > MAX_CITIES) ? CNT_W'(MAX_CITIES) : count_ff;

   tsp_control u_ctrl (
      .clock, .reset, .go(accept && req_word.action == ACT_START),
      .sts, .cmd, .busy, .emit
   );

   tsp_datapath #(.MAX_CITIES(MAX_CITIES), .COST_BITS(COST_BITS)) u_dp (
      .clock, .reset, .load_en(accept && req_word.action == ACT_LOAD),
      .req_word, .n_cities(n_sat), .cmd, .sts, .emit_word
   );

   assign rsp_valid = emit;
   assign rsp_word = emit_word;
endmodule

[rtl/tsp_checker.sv]
module tsp_checker
   import tsp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_word_type rsp_word
);
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside busy");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.last |=> !busy) else $error("busy after last");
   a_notfound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.found |-> rsp_word.last && rsp_word.tour_cost == '0)
      else $error("bad not-found word");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last |=> rsp_valid &&
      rsp_word.position == $past(rsp_word.position) + 4'd1)
      else $error("result gap");
endmodule

bind tsp_exhaustive_tour_search tsp_checker u_chk (
   .clock, .reset, .busy, .rsp_valid, .rsp_word
);
